@@ sv/rau_pkg.sv @@
// Package for the rational arithmetic unit: widths, payload structs,
// operation codes, controller states and command/status structs.
// No dependencies.
package rau_pkg;

    localparam int OPERAND_WIDTH = 16;
    localparam int DEN_WIDTH     = OPERAND_WIDTH - 1;
    localparam int PROD_WIDTH    = 2 * OPERAND_WIDTH;   // signed products
    localparam int RAW_WIDTH     = PROD_WIDTH + 1;      // signed sum of products
    localparam int MAG_WIDTH     = RAW_WIDTH;           // magnitudes (unsigned)
    localparam int CNT_WIDTH     = $clog2(MAG_WIDTH + 1);
    localparam int RES_NUM_WIDTH = 33;
    localparam int RES_DEN_WIDTH = 31;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0]                       op;
        logic signed [OPERAND_WIDTH-1:0]  a_num;
        logic [DEN_WIDTH-1:0]             a_den;
        logic signed [OPERAND_WIDTH-1:0]  b_num;
        logic [DEN_WIDTH-1:0]             b_den;
    } t_in_item;

    typedef struct packed {
        logic signed [RES_NUM_WIDTH-1:0] res_num;
        logic [RES_DEN_WIDTH-1:0]        res_den;
        logic                            zero_den_error;
        logic                            a_less_b;
        logic                            a_equal_b;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MULT,
        ST_RAW,
        ST_GCD,
        ST_DIV_NUM,
        ST_DIV_DEN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;       // capture input item
        logic raw;        // form raw pair from products
        logic gcd_start;  // start Euclid
        logic gcd_step;   // one remainder step
        logic div_start;  // start restoring divide of numerator
        logic div_den;    // start restoring divide of denominator
        logic div_step;   // one quotient bit
        logic finish;     // build result item
    } t_cmd;

    typedef struct packed {
        logic gcd_done;
        logic div_done;
        logic zero_den;
    } t_status;

endpackage

@@ sv/rau_ctrl.sv @@
// Controller state machine of the rational arithmetic unit.
// Depends on rau_pkg.
module rau_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output rau_pkg::t_cmd    o_cmd,
    input  rau_pkg::t_status i_status
);
    import rau_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:    if (i_in_valid) n_state = ST_MULT;
            ST_MULT:    n_state = ST_RAW;
            ST_RAW:     n_state = i_status.zero_den ? ST_DONE : ST_GCD;
            ST_GCD:     if (i_status.gcd_done) n_state = ST_DIV_NUM;
            ST_DIV_NUM: if (i_status.div_done) n_state = ST_DIV_DEN;
            ST_DIV_DEN: if (i_status.div_done) n_state = ST_DONE;
            ST_DONE:    if (!r_out_valid || i_out_ready) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // output register is free once taken; load it at the end of the item
    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        if (r_state == ST_DONE && (!r_out_valid || i_out_ready)) n_out_valid = 1'b1;
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.load      = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.raw       = (r_state == ST_RAW);
        o_cmd.gcd_start = (r_state == ST_RAW) && !i_status.zero_den;
        o_cmd.gcd_step  = (r_state == ST_GCD) && !i_status.gcd_done;
        o_cmd.div_start = (r_state == ST_GCD) && i_status.gcd_done;
        o_cmd.div_den   = (r_state == ST_DIV_NUM) && i_status.div_done;
        o_cmd.div_step  = ((r_state == ST_DIV_NUM) || (r_state == ST_DIV_DEN))
                          && !i_status.div_done;
        o_cmd.finish    = (r_state == ST_DONE) && (!r_out_valid || i_out_ready);
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef NO_ASSERTIONS
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == ST_MULT)
        else $error("load did not advance to multiply");
    a_finish_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> r_out_valid)
        else $error("finished item not presented");
    a_ready_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !(o_cmd.gcd_step || o_cmd.div_step))
        else $error("datapath busy while ready");
`endif
endmodule

@@ sv/rau_dp.sv @@
// Datapath of the rational arithmetic unit: products, raw pair,
// Euclid remainder unit, restoring divider, result register. Uses rau_pkg.
module rau_dp (
    input  logic              i_clk,
    input  rau_pkg::t_in_item i_in,
    input  rau_pkg::t_cmd     i_cmd,
    output rau_pkg::t_status  o_status,
    output rau_pkg::t_out_item o_out
);
    import rau_pkg::*;

    t_in_item r_in;
    logic signed [PROD_WIDTH-1:0] r_lhs, r_rhs, r_p3, r_p4;
    logic                         r_neg;
    logic [MAG_WIDTH-1:0]         r_mn, r_md;
    logic [MAG_WIDTH-1:0]         r_x, r_y;        // Euclid pair
    logic [MAG_WIDTH-1:0]         r_rem, r_quo, r_dvd;
    logic [CNT_WIDTH-1:0]         r_cnt;
    logic                         r_rem_busy;      // remainder x % y in progress
    logic [MAG_WIDTH-1:0]         r_qnum;
    logic                         r_zero;
    t_out_item                    r_out;

    logic signed [OPERAND_WIDTH:0] a_den_s, b_den_s;
    logic signed [RAW_WIDTH-1:0]   raw_n, raw_d;
    logic [MAG_WIDTH-1:0]          mag_n, mag_d;
    logic [MAG_WIDTH:0]            trial;
    logic [MAG_WIDTH-1:0]          div_by;
    logic                          rem_done;

    assign a_den_s = {2'b00, r_in.a_den};
    assign b_den_s = {2'b00, r_in.b_den};

    always_comb begin
        case (t_op'(r_in.op))
            OP_ADD:  begin raw_n = RAW_WIDTH'(r_lhs) + RAW_WIDTH'(r_rhs);
                           raw_d = RAW_WIDTH'(r_p4); end
            OP_SUB:  begin raw_n = RAW_WIDTH'(r_lhs) - RAW_WIDTH'(r_rhs);
                           raw_d = RAW_WIDTH'(r_p4); end
            OP_MUL:  begin raw_n = RAW_WIDTH'(r_p3);
                           raw_d = RAW_WIDTH'(r_p4); end
            default: begin raw_n = RAW_WIDTH'(r_lhs);
                           raw_d = RAW_WIDTH'(r_p3); end
        endcase
    end

    assign mag_n = raw_n[RAW_WIDTH-1] ? MAG_WIDTH'(-raw_n) : MAG_WIDTH'(raw_n);
    assign mag_d = raw_d[RAW_WIDTH-1] ? MAG_WIDTH'(-raw_d) : MAG_WIDTH'(raw_d);

    // one restoring step shared by Euclid remainder and reducing divides
    assign div_by = r_rem_busy ? r_y : r_x;
    assign trial  = {r_rem, r_dvd[MAG_WIDTH-1]} - {1'b0, div_by};
    assign rem_done = (r_cnt == '0);

    assign o_status.zero_den = (raw_d == '0);
    assign o_status.gcd_done = !r_rem_busy && (r_y == '0);
    assign o_status.div_done = rem_done;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_in <= i_in;
        // products: one multiplier each, registered
        r_lhs <= PROD_WIDTH'(r_in.a_num * b_den_s);
        r_rhs <= PROD_WIDTH'(r_in.b_num * a_den_s);
        r_p3  <= (t_op'(r_in.op) == OP_DIV) ? PROD_WIDTH'(a_den_s * r_in.b_num)
                                            : PROD_WIDTH'(r_in.a_num * r_in.b_num);
        r_p4  <= PROD_WIDTH'(a_den_s * b_den_s);
        if (i_cmd.raw) begin
            r_zero <= (raw_d == '0);
            r_neg  <= raw_n[RAW_WIDTH-1] ^ raw_d[RAW_WIDTH-1];
            r_mn   <= mag_n;
            r_md   <= mag_d;
        end
        if (i_cmd.gcd_start) begin
            r_x <= mag_n;
            r_y <= mag_d;
            r_rem_busy <= 1'b0;
        end else if (i_cmd.gcd_step) begin
            if (!r_rem_busy) begin
                // start x % y
                r_rem <= '0;
                r_dvd <= r_x;
                r_cnt <= CNT_WIDTH'(MAG_WIDTH);
                r_rem_busy <= 1'b1;
            end else if (!rem_done) begin
                r_rem <= trial[MAG_WIDTH] ? {r_rem[MAG_WIDTH-2:0], r_dvd[MAG_WIDTH-1]}
                                          : trial[MAG_WIDTH-1:0];
                r_dvd <= {r_dvd[MAG_WIDTH-2:0], 1'b0};
                r_cnt <= r_cnt - CNT_WIDTH'(1);
            end else begin
                r_x <= r_y;
                r_y <= r_rem;
                r_rem_busy <= 1'b0;
            end
        end
        // reducing divides by g (held in r_x)
        if (i_cmd.div_start || i_cmd.div_den) begin
            r_rem <= '0;
            r_dvd <= i_cmd.div_den ? r_md : r_mn;
            r_quo <= '0;
            r_cnt <= CNT_WIDTH'(MAG_WIDTH);
            if (i_cmd.div_den) r_qnum <= r_quo;
        end else if (i_cmd.div_step) begin
            r_rem <= trial[MAG_WIDTH] ? {r_rem[MAG_WIDTH-2:0], r_dvd[MAG_WIDTH-1]}
                                      : trial[MAG_WIDTH-1:0];
            r_quo <= {r_quo[MAG_WIDTH-2:0], ~trial[MAG_WIDTH]};
            r_dvd <= {r_dvd[MAG_WIDTH-2:0], 1'b0};
            r_cnt <= r_cnt - CNT_WIDTH'(1);
        end
        if (i_cmd.finish) begin
            if (r_zero) begin
                r_out.res_num        <= '0;
                r_out.res_den        <= RES_DEN_WIDTH'(1);
                r_out.zero_den_error <= 1'b1;
            end else begin
                r_out.res_num        <= RES_NUM_WIDTH'(r_neg ? -r_qnum : r_qnum);
                r_out.res_den        <= RES_DEN_WIDTH'(r_quo);
                r_out.zero_den_error <= 1'b0;
            end
            r_out.a_less_b  <= (r_lhs < r_rhs);
            r_out.a_equal_b <= (r_lhs == r_rhs);
        end
    end

    assign o_out = r_out;

`ifndef NO_ASSERTIONS
    a_gcd_nonzero: assert property (@(posedge i_clk)
        i_cmd.div_start |-> r_x != '0)
        else $error("gcd is zero at divide start");
    a_div_exact: assert property (@(posedge i_clk)
        i_cmd.div_den |-> r_rem == '0)
        else $error("numerator not divisible by gcd");
    a_den_exact: assert property (@(posedge i_clk)
        (i_cmd.finish && !r_zero) |-> r_rem == '0)
        else $error("denominator not divisible by gcd");
`endif
endmodule

@@ sv/rational_arithmetic_unit.sv @@
// Rational arithmetic unit: add, subtract, multiply or divide two fractions,
// reduce by the absolute gcd, and flag zero denominator and a<b / a==b.
// Each item passes capture, multiply, raw pair, Euclid remainder steps and the two
// reducing divides; a zero denominator skips Euclid and the divides.
// Throughput: one item in flight at a time, next accepted in the cycle after the
// result is loaded; set by the single shared bit-serial divide/remainder unit.
// Reset (synchronous, active low) clears the controller and the valid flag.
module rational_arithmetic_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  rau_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output rau_pkg::t_out_item  o_out_data
);
    import rau_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Sequence the item: capture, multiply, raw pair, Euclid, two divides.
    rau_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    // Hold operands, products, gcd and quotients; drive the result register.
    rau_dp u_dp (
        .i_clk    (i_clk),
        .i_in     (i_in_data),
        .i_cmd    (cmd),
        .o_status (status),
        .o_out    (o_out_data)
    );
endmodule

@@ verif/tb.sv @@
// Testbench for rational_arithmetic_unit: drives random and directed fraction
// operations, predicts each reduced result and checks it item by item.
// Depends on rau_pkg and the rational_arithmetic_unit RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rau_pkg::*;

    localparam int N_RANDOM    = 1200;
    localparam int CYCLE_LIMIT = 12000000;
    localparam int DRAIN_WAIT  = 800;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_data;

    rational_arithmetic_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data)
    );

    t_in_item  pending_items[$];
    t_out_item expected_results[$];
    int        errors = 0;
    int        cycles = 0;
    bit        calm = 0;          // last part of the run: no idling
    bit        hold_rx = 0;       // long receiver hold-off
    int        sent = 0;
    int        pause_at = -1;     // sender waits for drain at this count

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic longint unsigned euclid_gcd(longint unsigned x, longint unsigned y);
        longint unsigned t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // Compute the normalized fraction and the comparison flags for one item.
    function automatic t_out_item reduce_fraction(t_in_item it);
        t_out_item r;
        longint an, ad, bn, bd, lhs, rhs, rn, rd;
        longint unsigned mn, md, g;
        bit neg;
        an = longint'(it.a_num);
        ad = longint'({1'b0, it.a_den});
        bn = longint'(it.b_num);
        bd = longint'({1'b0, it.b_den});
        lhs = an * bd;
        rhs = bn * ad;
        case (t_op'(it.op))
            OP_ADD: begin rn = lhs + rhs; rd = ad * bd; end
            OP_SUB: begin rn = lhs - rhs; rd = ad * bd; end
            OP_MUL: begin rn = an * bn; rd = ad * bd; end
            default: begin rn = lhs; rd = ad * bn; end
        endcase
        if (rd == 0) begin
            r.res_num = '0;
            r.res_den = RES_DEN_WIDTH'(1);
            r.zero_den_error = 1'b1;
        end else begin
            neg = (rn < 0) != (rd < 0);
            mn = (rn < 0) ? -rn : rn;
            md = (rd < 0) ? -rd : rd;
            g = euclid_gcd(mn, md);
            mn = mn / g;
            md = md / g;
            r.res_num = RES_NUM_WIDTH'(neg ? -mn : mn);
            r.res_den = RES_DEN_WIDTH'(md);
            r.zero_den_error = 1'b0;
        end
        r.a_less_b  = lhs < rhs;
        r.a_equal_b = lhs == rhs;
        return r;
    endfunction

    function automatic t_in_item make_item(int op, int an, int ad, int bn, int bd);
        t_in_item it;
        it.op = op[1:0];
        it.a_num = an[15:0];
        it.a_den = ad[14:0];
        it.b_num = bn[15:0];
        it.b_den = bd[14:0];
        return it;
    endfunction

    // Draw a numerator: half the time full range, else an extreme or small value.
    function automatic int rand_num();
        case ($urandom_range(0, 5))
            0: return -32768;
            1: return 32767;
            2: return $urandom_range(0, 20) - 10;
            default: return $urandom_range(0, 65535) - 32768;
        endcase
    endfunction

    function automatic int rand_den();
        case ($urandom_range(0, 7))
            0: return 32767;
            1: return $urandom_range(1, 12);
            2: return ($urandom_range(0, 30) == 0) ? 0 : 1;
            default: return $urandom_range(1, 32767);
        endcase
    endfunction

    // Fill the stimulus queue: directed corners first, then random items.
    initial begin
        int k;
        for (k = 0; k < 4; k++) begin
            pending_items.push_back(make_item(k, 32767, 32767, -32768, 1));
            pending_items.push_back(make_item(k, -32768, 1, 32767, 32767));
            pending_items.push_back(make_item(k, 0, 5, 3, 7));
            pending_items.push_back(make_item(k, 3, 4, 3, 4));
        end
        pending_items.push_back(make_item(OP_DIV, 5, 3, 0, 9));      // divide by zero fraction
        pending_items.push_back(make_item(OP_ADD, 2, 0, 1, 3));      // zero denominator input
        pending_items.push_back(make_item(OP_MUL, 7, 3, 4, 0));
        pending_items.push_back(make_item(OP_SUB, 6, 4, 6, 4));      // zero numerator
        pending_items.push_back(make_item(OP_DIV, -32768, 1, -32768, 1));
        pending_items.push_back(make_item(OP_MUL, -32768, 1, -32768, 1));
        pending_items.push_back(make_item(OP_ADD, -1, 32767, -1, 32766));
        for (k = 0; k < N_RANDOM; k++)
            pending_items.push_back(make_item($urandom_range(0, 3), rand_num(), rand_den(),
                                              rand_num(), rand_den()));
        pause_at = 300;
    end

    // Driver: offer items from the queue, idling in random bursts.
    int tx_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                expected_results.push_back(reduce_fraction(i_in_data));
                sent++;
            end
            if (!i_in_valid || o_in_ready) begin
                // current item is gone (or none): decide what comes next
                if (tx_gap > 0) begin
                    tx_gap--;
                    i_in_valid <= 1'b0;
                end else if (sent == pause_at && (expected_results.size() != 0
                             || (i_in_valid && o_in_ready))) begin
                    i_in_valid <= 1'b0;   // hold until every result has come
                end else if (pending_items.size() == 0) begin
                    i_in_valid <= 1'b0;
                end else if (!calm && $urandom_range(0, 9) == 0) begin
                    tx_gap = $urandom_range(1, 15) - 1;
                    i_in_valid <= 1'b0;
                end else begin
                    i_in_data  <= pending_items.pop_front();
                    i_in_valid <= 1'b1;
                end
            end
        end
    end

    // Receiver backpressure in its own process, with one long hold-off.
    int rx_gap = 0;
    int hold_count = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (sent >= 100 && sent < 104 && hold_count < 3000) begin
            hold_count++;
            i_out_ready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            i_out_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            rx_gap = $urandom_range(1, 15) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Monitor: compare each accepted result against the oldest expectation.
    always @(posedge i_clk) begin
        t_out_item exp_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result %h", $realtime, o_out_data);
                errors++;
            end else begin
                exp_r = expected_results.pop_front();
                if (exp_r.res_num !== o_out_data.res_num)
                    $display("%0t: res_num expected %0d actual %0d", $realtime,
                             exp_r.res_num, o_out_data.res_num);
                if (exp_r.res_den !== o_out_data.res_den)
                    $display("%0t: res_den expected %0d actual %0d", $realtime,
                             exp_r.res_den, o_out_data.res_den);
                if (exp_r.zero_den_error !== o_out_data.zero_den_error)
                    $display("%0t: zero_den_error expected %b actual %b", $realtime,
                             exp_r.zero_den_error, o_out_data.zero_den_error);
                if (exp_r.a_less_b !== o_out_data.a_less_b)
                    $display("%0t: a_less_b expected %b actual %b", $realtime,
                             exp_r.a_less_b, o_out_data.a_less_b);
                if (exp_r.a_equal_b !== o_out_data.a_equal_b)
                    $display("%0t: a_equal_b expected %b actual %b", $realtime,
                             exp_r.a_equal_b, o_out_data.a_equal_b);
                if (exp_r !== o_out_data)
                    errors++;
            end
        end
    end

    // Cycle limit guards against a hung handshake.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int w;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_out_ready = 1'b0;
        i_in_data = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // drop idling for the last stretch of items
        wait (pending_items.size() < 150);
        calm = 1;
        wait (pending_items.size() == 0);
        @(posedge i_clk);
        while (i_in_valid) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        for (w = 0; w < DRAIN_WAIT; w++) @(posedge i_clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
